// ===== hw/rtl/scb_pkg.sv =====
// Speaker channel birth gate: shared types, register indexes and reset values.
// Used by every module of the block; depends on nothing.
package scb_pkg;

  localparam int MAX_CH = 4;
  localparam int PROB_W = 16;
  localparam int CNT_W  = 8;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BIRTH_SPEECH   = 3'd0,
    REG_CLEAN_BIRTH    = 3'd1,
    REG_QUIET_EST      = 3'd2,
    REG_FADING_BIRTH   = 3'd3,
    REG_FADING_EST     = 3'd4,
    REG_CLEAN_NEEDED   = 3'd5,
    REG_FADING_NEEDED  = 3'd6,
    REG_EPISODE_GAP    = 3'd7
  } reg_idx_t;

  // Reset values (Q1.15 levels, frame counts)
  localparam logic [PROB_W-1:0] RST_BIRTH_SPEECH  = 16'd9830;
  localparam logic [PROB_W-1:0] RST_CLEAN_BIRTH   = 16'd31130;
  localparam logic [PROB_W-1:0] RST_QUIET_EST     = 16'd655;
  localparam logic [PROB_W-1:0] RST_FADING_BIRTH  = 16'd29491;
  localparam logic [PROB_W-1:0] RST_FADING_EST    = 16'd4915;
  localparam logic [CNT_W-1:0]  RST_CLEAN_NEEDED  = 8'd4;
  localparam logic [CNT_W-1:0]  RST_FADING_NEEDED = 8'd20;
  localparam logic [CNT_W-1:0]  RST_EPISODE_GAP   = 8'd25;

  typedef struct packed {
    logic [PROB_W-1:0] birth_speech_level;
    logic [PROB_W-1:0] clean_birth_level;
    logic [PROB_W-1:0] quiet_established_level;
    logic [PROB_W-1:0] fading_birth_level;
    logic [PROB_W-1:0] fading_established_level;
    logic [CNT_W-1:0]  clean_frames_needed;
    logic [CNT_W-1:0]  fading_frames_needed;
    logic [CNT_W-1:0]  episode_gap_frames;
  } cfg_t;

  // Input beat
  typedef struct packed {
    logic [PROB_W-1:0] prob_0;
    logic [PROB_W-1:0] prob_1;
    logic [PROB_W-1:0] prob_2;
    logic [PROB_W-1:0] prob_3;
  } frame_t;

  // Output beat
  typedef struct packed {
    logic [PROB_W-1:0]  out_prob_0;
    logic [PROB_W-1:0]  out_prob_1;
    logic [PROB_W-1:0]  out_prob_2;
    logic [PROB_W-1:0]  out_prob_3;
    logic [MAX_CH-1:0]  established_mask;
    logic               newly_established;
  } result_t;

  // Frame-wide view given to each lane, with is_win set only in the winner's lane
  typedef struct packed {
    logic              accept;
    logic              is_win;
    logic [PROB_W-1:0] win_prob;
    logic [PROB_W-1:0] est_prob;
  } lane_in_t;

  // Per-lane status back to the top
  typedef struct packed {
    logic flag;
    logic flag_next;
    logic newly;
  } lane_stat_t;

endpackage

// ===== hw/rtl/scb_lane.sv =====
// One speaker lane: run counters, age counter and established flag.
// Depends on scb_pkg.
module scb_lane (
  input  logic              clk,
  input  logic              rst,
  input  scb_pkg::cfg_t      cfg,
  input  scb_pkg::lane_in_t  lin,
  output scb_pkg::lane_stat_t stat
);

  logic                       flag;
  logic [scb_pkg::CNT_W-1:0]  clean_cnt;
  logic [scb_pkg::CNT_W-1:0]  fading_cnt;
  logic [scb_pkg::CNT_W-1:0]  age;

  logic                       count_en;
  logic                       restart;
  logic [scb_pkg::CNT_W-1:0]  clean_base;
  logic [scb_pkg::CNT_W-1:0]  fading_base;
  logic [scb_pkg::CNT_W-1:0]  clean_next;
  logic [scb_pkg::CNT_W-1:0]  fading_next;
  logic [scb_pkg::CNT_W-1:0]  age_next;
  logic                       reach;

  // Counting decision for this beat
  always_comb begin
    count_en   = lin.accept && lin.is_win && !flag &&
                 (lin.win_prob >= cfg.birth_speech_level);
    restart    = age > cfg.episode_gap_frames;
    clean_base  = restart ? '0 : clean_cnt;
    fading_base = restart ? '0 : fading_cnt;

    clean_next = clean_base;
    if (lin.win_prob >= cfg.clean_birth_level &&
        lin.est_prob <= cfg.quiet_established_level &&
        clean_base != scb_pkg::CNT_MAX) begin
      clean_next = clean_base + 8'd1;
    end
    fading_next = fading_base;
    if (lin.win_prob >= cfg.fading_birth_level &&
        lin.est_prob <= cfg.fading_established_level &&
        fading_base != scb_pkg::CNT_MAX) begin
      fading_next = fading_base + 8'd1;
    end

    reach = (clean_next >= cfg.clean_frames_needed) ||
            (fading_next >= cfg.fading_frames_needed);

    // a counted win sets the age to 1, else each accepted frame ages it by one up to CNT_MAX
    if (count_en) begin
      age_next = 8'd1;
    end else if (age == scb_pkg::CNT_MAX) begin
      age_next = age;
    end else begin
      age_next = age + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag       <= 1'b0;
      clean_cnt  <= '0;
      fading_cnt <= '0;
      age        <= scb_pkg::CNT_MAX;
    end else if (lin.accept) begin
      age <= age_next;
      if (count_en) begin
        clean_cnt  <= clean_next;
        fading_cnt <= fading_next;
        if (reach) begin
          flag <= 1'b1;
        end
      end
    end
  end

  assign stat.flag      = flag;
  assign stat.newly     = count_en && reach;
  assign stat.flag_next = flag || (count_en && reach);

endmodule

// ===== hw/rtl/scb_merge.sv =====
// Merge stage: folds non-established channels into the loudest established one,
// if any, and holds the result register. Depends on scb_pkg.
module scb_merge (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                load,
  input  logic                                drain,
  input  logic [scb_pkg::PROB_W-1:0]          prob [scb_pkg::MAX_CH],
  input  logic [scb_pkg::MAX_CH-1:0]          flags,
  input  logic                                newly,
  output logic                                result_valid,
  output scb_pkg::result_t                    result
);

  logic [scb_pkg::PROB_W-1:0] folded [scb_pkg::MAX_CH];
  logic [1:0]                 target;
  logic                       have_target;
  logic [scb_pkg::PROB_W-1:0] loose_max;
  logic [scb_pkg::PROB_W-1:0] merged;

  // Pick the loudest established channel, lower index on ties
  always_comb begin
    target      = '0;
    have_target = 1'b0;
    loose_max   = '0;
    for (int s = 0; s < scb_pkg::MAX_CH; s++) begin
      if (flags[s] && (!have_target || prob[s] > prob[target])) begin
        target      = 2'(s);
        have_target = 1'b1;
      end
      if (!flags[s] && prob[s] > loose_max) begin
        loose_max = prob[s];
      end
    end
    merged = (loose_max > prob[target]) ? loose_max : prob[target];

    for (int s = 0; s < scb_pkg::MAX_CH; s++) begin
      if (!have_target) begin
        folded[s] = prob[s];
      end else if (!flags[s]) begin
        folded[s] = '0;
      end else if (target == 2'(s)) begin
        folded[s] = merged;
      end else begin
        folded[s] = prob[s];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (drain) begin
      result_valid <= 1'b0;
    end
    if (load) begin
      result.out_prob_0        <= folded[0];
      result.out_prob_1        <= folded[1];
      result.out_prob_2        <= folded[2];
      result.out_prob_3        <= folded[3];
      result.established_mask  <= flags;
      result.newly_established <= newly;
    end
  end

endmodule

// ===== hw/rtl/speaker_channel_birth_gate_top.sv =====
// Speaker channel birth gate, top level: config registers, winner pick, lanes,
// frame stage and merge. Depends on scb_pkg, scb_lane, scb_merge.
//
// Takes one frame of Q1.15 speaker probabilities per cycle while frame_stall is
// low and returns one relabeled frame per input. A frame's state update (arg-max
// winner, threshold compares, run counters, establish decision) completes in the
// cycle it is accepted, so a new frame can enter every cycle unless stalled.
// Results pass the frame stage, then the result register. frame_stall rises
// only when both stages hold beats and result_stall is high. Configuration
// writes take effect at the next edge and are meant for idle periods only.
module speaker_channel_birth_gate_top #(
  parameter int NUM_SPEAKERS = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       frame_valid,
  output logic                       frame_stall,
  input  scb_pkg::frame_t            frame,
  output logic                       result_valid,
  input  logic                       result_stall,
  output scb_pkg::result_t           result,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [scb_pkg::PROB_W-1:0] cfg_data
);

  scb_pkg::cfg_t               cfg;
  logic [scb_pkg::PROB_W-1:0]  prob [scb_pkg::MAX_CH];
  logic                        accept;
  logic [1:0]                  win;
  logic [scb_pkg::PROB_W-1:0]  win_prob;
  logic [scb_pkg::PROB_W-1:0]  est_prob;
  scb_pkg::lane_stat_t         stat [scb_pkg::MAX_CH];
  logic [scb_pkg::MAX_CH-1:0]  flags_next;
  logic                        any_newly;

  logic                        s1_valid;
  logic [scb_pkg::PROB_W-1:0]  s1_prob [scb_pkg::MAX_CH];
  logic [scb_pkg::MAX_CH-1:0]  s1_flags;
  logic                        s1_newly;
  logic                        out_ready;
  logic                        s1_move;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.birth_speech_level       <= scb_pkg::RST_BIRTH_SPEECH;
      cfg.clean_birth_level        <= scb_pkg::RST_CLEAN_BIRTH;
      cfg.quiet_established_level  <= scb_pkg::RST_QUIET_EST;
      cfg.fading_birth_level       <= scb_pkg::RST_FADING_BIRTH;
      cfg.fading_established_level <= scb_pkg::RST_FADING_EST;
      cfg.clean_frames_needed      <= scb_pkg::RST_CLEAN_NEEDED;
      cfg.fading_frames_needed     <= scb_pkg::RST_FADING_NEEDED;
      cfg.episode_gap_frames       <= scb_pkg::RST_EPISODE_GAP;
    end else if (cfg_we) begin
      case (cfg_index)
        scb_pkg::REG_BIRTH_SPEECH:  cfg.birth_speech_level       <= cfg_data;
        scb_pkg::REG_CLEAN_BIRTH:   cfg.clean_birth_level        <= cfg_data;
        scb_pkg::REG_QUIET_EST:     cfg.quiet_established_level  <= cfg_data;
        scb_pkg::REG_FADING_BIRTH:  cfg.fading_birth_level       <= cfg_data;
        scb_pkg::REG_FADING_EST:    cfg.fading_established_level <= cfg_data;
        scb_pkg::REG_CLEAN_NEEDED:  cfg.clean_frames_needed      <= cfg_data[7:0];
        scb_pkg::REG_FADING_NEEDED: cfg.fading_frames_needed     <= cfg_data[7:0];
        scb_pkg::REG_EPISODE_GAP:   cfg.episode_gap_frames       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Handshake: stall only when the frame stage is full and cannot move on
  assign out_ready   = !result_valid || !result_stall;
  assign s1_move     = s1_valid && out_ready;
  assign frame_stall = s1_valid && !out_ready;
  assign accept      = frame_valid && !frame_stall;

  // Inactive speakers read as silent
  always_comb begin
    prob[0] = frame.prob_0;
    prob[1] = (NUM_SPEAKERS > 1) ? frame.prob_1 : '0;
    prob[2] = (NUM_SPEAKERS > 2) ? frame.prob_2 : '0;
    prob[3] = (NUM_SPEAKERS > 3) ? frame.prob_3 : '0;
  end

  // Winner (ties to lower index) and loudest currently established channel
  always_comb begin
    win      = '0;
    win_prob = prob[0];
    est_prob = '0;
    for (int s = 1; s < scb_pkg::MAX_CH; s++) begin
      if (prob[s] > win_prob) begin
        win      = 2'(s);
        win_prob = prob[s];
      end
    end
    for (int s = 0; s < scb_pkg::MAX_CH; s++) begin
      if (stat[s].flag && prob[s] > est_prob) begin
        est_prob = prob[s];
      end
    end
  end

  // Lanes
  for (genvar s = 0; s < scb_pkg::MAX_CH; s++) begin : g_lane
    if (s < NUM_SPEAKERS) begin : g_on
      scb_pkg::lane_in_t lin;
      assign lin.accept   = accept;
      assign lin.is_win   = (win == 2'(s));
      assign lin.win_prob = win_prob;
      assign lin.est_prob = est_prob;
      scb_lane u_lane (
        .clk  (clk),
        .rst  (rst),
        .cfg  (cfg),
        .lin  (lin),
        .stat (stat[s])
      );
    end else begin : g_off
      assign stat[s] = '0;
    end
    assign flags_next[s] = stat[s].flag_next;
  end

  always_comb begin
    any_newly = 1'b0;
    for (int s = 0; s < scb_pkg::MAX_CH; s++) begin
      any_newly = any_newly | stat[s].newly;
    end
  end

  // Frame stage: holds the frame with its updated flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_prob  <= prob;
      s1_flags <= flags_next;
      s1_newly <= any_newly;
    end
  end

  scb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .load         (s1_move),
    .drain        (!result_stall),
    .prob         (s1_prob),
    .flags        (s1_flags),
    .newly        (s1_newly),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

// ===== hw/rtl/scb_checker.sv =====
// Port-level checks for the speaker channel birth gate, bound to the top level.
// Depends on scb_pkg and speaker_channel_birth_gate_top.
module scb_checker (
  input logic             clk,
  input logic             rst,
  input logic             result_valid,
  input logic             result_stall,
  input scb_pkg::result_t result
);

  // A stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result beat changed under stall");

  // No result right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  // A new establishment shows in the mask
  a_newly: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.newly_established |-> result.established_mask != '0)
    else $error("newly established with empty mask");

  // Once anyone is established, every non-established channel is folded to zero
  a_fold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.established_mask != '0 |->
      (result.established_mask[0] || result.out_prob_0 == '0) &&
      (result.established_mask[1] || result.out_prob_1 == '0) &&
      (result.established_mask[2] || result.out_prob_2 == '0) &&
      (result.established_mask[3] || result.out_prob_3 == '0))
    else $error("non-established channel not folded");

endmodule

bind speaker_channel_birth_gate_top scb_checker u_scb_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
